FILE: hdl/dcp_pkg.sv
// ----------------------------------------------------------------------------
// dcp_pkg
// Types, constants and the month table shared by the DOS clock packet block.
// ----------------------------------------------------------------------------
package dcp_pkg;

  // Access codes carried on the func field
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam int PKT_LEN = 6;

  // floor(y / 400) for y < 4096 as (y * 2622) >> 20
  localparam logic [11:0] ERA_RECIP = 12'd2622;
  localparam int          ERA_SHIFT = 20;
  localparam logic [8:0]  ERA_YEARS = 9'd400;
  localparam logic [8:0]  LAST_YOE  = 9'd399;

  // floor(us / 10000) for us < 2^20 as (us * 1717987) >> 34
  localparam logic [20:0] HUND_RECIP = 21'd1717987;
  localparam int          HUND_SHIFT = 34;

  // floor(yoe / 100) for yoe < 400 as (yoe * 41) >> 12
  localparam logic [5:0] CENT_RECIP = 6'd41;
  localparam int         CENT_SHIFT = 12;

  localparam logic [8:0] YEAR_DAYS = 9'd365;

  // Day count is kept modulo 2^16: 146097 mod 65536, and the epoch offset
  // (719468 plus the days from 1970 to 1980) mod 65536.
  localparam logic [15:0] ERA_DAYS  = 16'd15025;
  localparam logic [15:0] EPOCH_ADJ = 16'd2224;

  typedef struct packed {
    logic        func;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [19:0] microsecond;
  } item_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [6:0] hund;
  } clk_fields_t;

  typedef struct packed {
    logic        func;
    logic        neg;      // shifted year is -1 (year 0, Jan/Feb)
    logic [11:0] ylow;
    logic [3:0]  era;
    logic [15:0] doy;
    clk_fields_t tf;
  } s1_t;

  typedef struct packed {
    logic        func;
    logic [8:0]  yoe;
    logic [15:0] base;
    clk_fields_t tf;
  } s2_t;

  typedef struct packed {
    logic        func;
    logic [15:0] days;
    clk_fields_t tf;
  } done_t;

  // (153 * mp + 2) / 5 with mp the March-based month index
  function automatic logic [8:0] doy_base(input logic [3:0] month);
    logic [8:0] res;
    case (month)
      4'd0:    res = 9'd275;
      4'd1:    res = 9'd306;
      4'd2:    res = 9'd337;
      4'd3:    res = 9'd0;
      4'd4:    res = 9'd31;
      4'd5:    res = 9'd61;
      4'd6:    res = 9'd92;
      4'd7:    res = 9'd122;
      4'd8:    res = 9'd153;
      4'd9:    res = 9'd184;
      4'd10:   res = 9'd214;
      4'd11:   res = 9'd245;
      4'd12:   res = 9'd275;
      4'd13:   res = 9'd306;
      4'd14:   res = 9'd337;
      default: res = 9'd367;
    endcase
    return res;
  endfunction

endpackage

FILE: hdl/civil_date_to_dos_clock_packet.sv
// ----------------------------------------------------------------------------
// civil_date_to_dos_clock_packet
// Clock register of an emulated I/O card: a write captures date and time
// into a six-byte DOS packet, each read returns the next packet byte.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Payload
//  in_      input      in_valid / in_stall   func, year, month, day, hour,
//                                            minute, second, microsecond
//  out_     output     out_valid / out_stall read_data
//
//  One transfer per cycle is sustained in both directions while out_stall is low.
//  Registers in order: the input register, two date arithmetic stages,
//  then the packet update and result register.
//  Each stage moves whenever it is empty or its successor moves, so bubbles
//  close up and input keeps being taken while a result waits under out_stall,
//  until all four registers hold a transfer; then in_stall rises.
//  rst_n (synchronous) empties the pipe, clears the packet and the pointer.
//
module civil_date_to_dos_clock_packet (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  input  logic [19:0] in_microsecond,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data
);
  import dcp_pkg::*;

  item_t in_item;
  done_t done_item;
  logic  in_ready;
  logic  done_valid;
  logic  done_ready;

  always_comb begin
    in_item.func        = in_func;
    in_item.year        = in_year;
    in_item.month       = in_month;
    in_item.day         = in_day;
    in_item.hour        = in_hour;
    in_item.minute      = in_minute;
    in_item.second      = in_second;
    in_item.microsecond = in_microsecond;
  end

  assign in_stall = !in_ready;

  // Day count arithmetic; the packet state is touched only past this point,
  // so reads always see the packet of the latest earlier write.
  dcp_date_pipe u_date_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_ready  (in_ready),
    .out_valid (done_valid),
    .out_item  (done_item),
    .out_ready (done_ready)
  );

  // Packet bytes, read pointer and the result register
  dcp_packet_store u_packet_store (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (done_valid),
    .item          (done_item),
    .item_ready    (done_ready),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_stall     (out_stall)
  );

endmodule

FILE: hdl/dcp_date_pipe.sv
// ----------------------------------------------------------------------------
// dcp_date_pipe
// Input register and two arithmetic stages turning a civil date into a
// 16-bit day count since 1980-01-01.
// ----------------------------------------------------------------------------
module dcp_date_pipe (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  dcp_pkg::item_t in_item,
  output logic           in_ready,
  output logic           out_valid,
  output dcp_pkg::done_t out_item,
  input  logic           out_ready
);
  import dcp_pkg::*;

  logic  v0_r, v1_r, v2_r;
  logic  v0_nxt, v1_nxt, v2_nxt;
  logic  mv0, mv1, mv2;
  item_t s0_r;
  s1_t   s1_r, s1_nxt;
  s2_t   s2_r, s2_nxt;

  // stage moves when empty or when the next one moves
  assign mv2      = !v2_r || out_ready;
  assign mv1      = !v1_r || mv2;
  assign mv0      = !v0_r || mv1;
  assign in_ready = mv0;

  always_comb begin
    v0_nxt = mv0 ? in_valid : v0_r;
    v1_nxt = mv1 ? v0_r     : v1_r;
    v2_nxt = mv2 ? v1_r     : v2_r;
  end

  // Stage 1: shifted year, era, day of year, hundredths
  logic        dec;
  logic [23:0] era_prod;
  logic [40:0] hund_prod;
  logic [15:0] doy_sum;

  always_comb begin
    dec       = (s0_r.month <= 4'd2);
    era_prod  = 24'(s0_r.year - 12'(dec)) * 24'(ERA_RECIP);
    hund_prod = 41'(s0_r.microsecond) * 41'(HUND_RECIP);
    doy_sum   = 16'(doy_base(s0_r.month)) + 16'(s0_r.day) - 16'd1;

    s1_nxt.func      = s0_r.func;
    s1_nxt.neg       = dec && (s0_r.year == 12'd0);
    s1_nxt.ylow      = s0_r.year - 12'(dec);
    s1_nxt.era       = era_prod[ERA_SHIFT +: 4];
    s1_nxt.doy       = doy_sum;
    s1_nxt.tf.hour   = s0_r.hour;
    s1_nxt.tf.minute = s0_r.minute;
    s1_nxt.tf.second = s0_r.second;
    s1_nxt.tf.hund   = hund_prod[HUND_SHIFT +: 7];
  end

  // Stage 2: year of era and era contribution to the day count
  logic [15:0] era16;
  logic [11:0] era_years;

  always_comb begin
    era_years = 12'(s1_r.era) * 12'(ERA_YEARS);
    if (s1_r.neg) begin
      era16      = 16'hFFFF;
      s2_nxt.yoe = LAST_YOE;
    end else begin
      era16      = 16'(s1_r.era);
      s2_nxt.yoe = 9'(s1_r.ylow - era_years);
    end
    s2_nxt.func = s1_r.func;
    s2_nxt.base = era16 * ERA_DAYS + s1_r.doy - EPOCH_ADJ;
    s2_nxt.tf   = s1_r.tf;
  end

  // Final sum, registered downstream
  logic [13:0] cent_prod;

  always_comb begin
    cent_prod      = 14'(s2_r.yoe) * 14'(CENT_RECIP);
    out_item.func  = s2_r.func;
    out_item.days  = s2_r.base + 16'(s2_r.yoe) * 16'(YEAR_DAYS)
                   + 16'(s2_r.yoe[8:2]) - 16'(cent_prod[13:CENT_SHIFT]);
    out_item.tf    = s2_r.tf;
  end
  assign out_valid = v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mv0 && in_valid) begin
      s0_r <= in_item;
    end
    if (mv1 && v0_r) begin
      s1_r <= s1_nxt;
    end
    if (mv2 && v1_r) begin
      s2_r <= s2_nxt;
    end
  end

  a_free_in: assert property (@(posedge clk) disable iff (!rst_n)
    !v0_r |-> in_ready) else $error("input blocked with empty first stage");

  a_hold_s2: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !out_ready) |=> (v2_r && $stable(s2_r)))
    else $error("stage 2 lost an item under backpressure");

endmodule

FILE: hdl/dcp_packet_store.sv
// ----------------------------------------------------------------------------
// dcp_packet_store
// Six-byte packet, read pointer and result register.
// ----------------------------------------------------------------------------
module dcp_packet_store (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  input  dcp_pkg::done_t item,
  output logic           item_ready,
  output logic           out_valid,
  output logic [7:0]     out_read_data,
  input  logic           out_stall
);
  import dcp_pkg::*;

  localparam logic [2:0] PTR_LAST = 3'(PKT_LEN - 1);

  logic [7:0] pkt_r [PKT_LEN];
  logic [7:0] pkt_nxt [PKT_LEN];
  logic [2:0] ptr_r, ptr_nxt, ptr_cur;
  logic       valid_r, valid_nxt;
  logic [7:0] data_r, data_nxt;
  logic       take;

  assign item_ready = !valid_r || !out_stall;
  assign take       = item_valid && item_ready;

  always_comb begin
    pkt_nxt   = pkt_r;
    ptr_nxt   = ptr_r;
    data_nxt  = data_r;
    valid_nxt = valid_r && out_stall;
    ptr_cur   = (ptr_r > PTR_LAST) ? 3'd0 : ptr_r;
    if (take) begin
      valid_nxt = 1'b1;
      if (item.func == FUNC_WRITE) begin
        pkt_nxt[0] = item.days[7:0];
        pkt_nxt[1] = item.days[15:8];
        pkt_nxt[2] = 8'(item.tf.minute);
        pkt_nxt[3] = 8'(item.tf.hour);
        pkt_nxt[4] = 8'(item.tf.hund);
        pkt_nxt[5] = 8'(item.tf.second);
        ptr_nxt    = 3'd0;
        data_nxt   = 8'd0;
      end else begin
        data_nxt = pkt_r[ptr_cur];
        ptr_nxt  = (ptr_cur == PTR_LAST) ? 3'd0 : ptr_cur + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PKT_LEN; i++) begin
        pkt_r[i] <= 8'd0;
      end
      ptr_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      pkt_r   <= pkt_nxt;
      ptr_r   <= ptr_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid     = valid_r;
  assign out_read_data = data_r;

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PTR_LAST) else $error("read pointer beyond packet");

  a_wr_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.func == FUNC_WRITE) |=> (ptr_r == 3'd0 && data_r == 8'd0))
    else $error("write did not rewind pointer or return zero");

  a_rd_step: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.func == FUNC_READ && ptr_r != PTR_LAST)
      |=> (ptr_r == $past(ptr_r) + 3'd1))
    else $error("read did not advance pointer");

endmodule
